// File: design/cgo_pkg.sv
// Shared types, register codes and helpers for the circular gradient operator.
// No dependencies; imported by circular_gradient_operator and cgo_axis_unit.
`default_nettype none

package cgo_pkg;

    localparam int PART_W     = 16;
    localparam int NPARTS     = 6;
    localparam int WORD_W     = PART_W * NPARTS;
    localparam int SIZE_W     = 6;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int ROUND_SH   = 15;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SIZE_X = 3'd0;
    localparam cfg_idx_t REG_SIZE_Y = 3'd1;
    localparam cfg_idx_t REG_SIZE_Z = 3'd2;
    localparam cfg_idx_t REG_MODE   = 3'd3;
    localparam cfg_idx_t REG_GAIN   = 3'd4;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic MODE_GRAD = 1'b0;
    localparam logic MODE_ADJ  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd9459;

    typedef logic signed [PART_W-1:0] sample_t;
    typedef logic signed [16:0]       diff_t;
    typedef logic signed [32:0]       prod_t;
    typedef logic signed [19:0]       acc_t;
    typedef logic [WORD_W-1:0]        word_t;
    typedef logic [1:0]               axis_t;
    typedef logic [2:0]               part_idx_t;

    localparam prod_t ROUND_HALF = 33'sd16384;

    // tag travelling alongside a memory read
    typedef struct packed {
        logic  vld;
        logic  here;
        logic  last;
        axis_t axis;
    } tag_t;

    typedef struct packed {
        sample_t [2:0] re;
        sample_t [2:0] im;
        logic          clip;
    } result_t;

    typedef struct packed {
        logic    clip;
        sample_t val;
    } sat_t;

    function automatic sample_t pick_part(word_t w, part_idx_t idx);
        sample_t p;
        case (idx)
            3'd0:    p = w[15:0];
            3'd1:    p = w[31:16];
            3'd2:    p = w[47:32];
            3'd3:    p = w[63:48];
            3'd4:    p = w[79:64];
            3'd5:    p = w[95:80];
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic sat_t sat16(acc_t v);
        sat_t s;
        if (v > acc_t'(32767)) begin
            s.clip = 1'b1;
            s.val  = 16'sh7FFF;
        end else if (v < acc_t'(-32768)) begin
            s.clip = 1'b1;
            s.val  = 16'sh8000;
        end else begin
            s.clip = 1'b0;
            s.val  = v[15:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: design/cgo_volume_mem.sv
// Volume store: single write port, single registered read port.
// Depends on nothing; instantiated by circular_gradient_operator.
`default_nettype none

module cgo_volume_mem #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 96
) (
    input  logic              aclk,
    input  logic              we_i,
    input  logic [ADDR_W-1:0] waddr_i,
    input  logic [DATA_W-1:0] wdata_i,
    input  logic              re_i,
    input  logic [ADDR_W-1:0] raddr_i,
    output logic [DATA_W-1:0] rdata_o
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
        if (re_i) begin
            rdata_reg <= mem[raddr_i];
        end
    end

    assign rdata_o = rdata_reg;

endmodule

`default_nettype wire

// File: design/cgo_axis_unit.sv
// Difference, gain multiply, rounding and saturation/accumulation per axis.
// Depends on cgo_pkg; fed by the read port of cgo_volume_mem.
`default_nettype none

module cgo_axis_unit import cgo_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  tag_t              tag_i,
    input  word_t             rd_data_i,
    input  logic              mode_i,
    input  logic [GAIN_W-1:0] gain_i,
    output logic              done_o,
    output result_t           result_o
);

    word_t         here_reg;
    tag_t          d1_tag_reg;
    diff_t         d1_re_reg, d1_im_reg;
    tag_t          p2_tag_reg;
    prod_t         p2_re_reg, p2_im_reg;
    sample_t [2:0] grad_re_reg, grad_im_reg;
    logic          clip_reg;
    acc_t          acc_re_reg, acc_im_reg;
    logic          done_reg;

    part_idx_t idx_re, idx_im;
    diff_t     d1_re_next, d1_im_next;
    prod_t     gain_s;
    prod_t     rnd_re, rnd_im;
    acc_t      r_re, r_im;
    sat_t      s_re, s_im;
    sat_t      a_re, a_im;

    // gradient always uses component 0; adjoint uses component k for axis k
    always_comb begin
        idx_re = (mode_i == MODE_ADJ) ? {tag_i.axis, 1'b0} : 3'd0;
        idx_im = (mode_i == MODE_ADJ) ? {tag_i.axis, 1'b1} : 3'd1;
        d1_re_next = diff_t'(pick_part(rd_data_i, idx_re)) - diff_t'(pick_part(here_reg, idx_re));
        d1_im_next = diff_t'(pick_part(rd_data_i, idx_im)) - diff_t'(pick_part(here_reg, idx_im));
    end

    assign gain_s = prod_t'($signed({1'b0, gain_i}));

    // floor((p + 2^14) / 2^15)
    always_comb begin
        rnd_re = (p2_re_reg + ROUND_HALF) >>> ROUND_SH;
        rnd_im = (p2_im_reg + ROUND_HALF) >>> ROUND_SH;
        r_re   = acc_t'(rnd_re);
        r_im   = acc_t'(rnd_im);
        s_re   = sat16(r_re);
        s_im   = sat16(r_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_tag_reg <= '0;
            p2_tag_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            d1_tag_reg <= tag_i.here ? '0 : tag_i;
            p2_tag_reg <= d1_tag_reg;
            done_reg   <= p2_tag_reg.vld && p2_tag_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_i.vld && tag_i.here) begin
            here_reg <= rd_data_i;
        end
        d1_re_reg <= d1_re_next;
        d1_im_reg <= d1_im_next;
        p2_re_reg <= prod_t'(d1_re_reg) * gain_s;
        p2_im_reg <= prod_t'(d1_im_reg) * gain_s;

        if (tag_i.vld && tag_i.here) begin
            grad_re_reg <= '0;
            grad_im_reg <= '0;
            clip_reg    <= 1'b0;
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
        end else if (p2_tag_reg.vld) begin
            if (mode_i == MODE_ADJ) begin
                acc_re_reg <= acc_re_reg + r_re;
                acc_im_reg <= acc_im_reg + r_im;
            end else begin
                grad_re_reg[p2_tag_reg.axis] <= s_re.val;
                grad_im_reg[p2_tag_reg.axis] <= s_im.val;
                clip_reg <= clip_reg | s_re.clip | s_im.clip;
            end
        end
    end

    always_comb begin
        a_re = sat16(acc_re_reg);
        a_im = sat16(acc_im_reg);
        if (mode_i == MODE_ADJ) begin
            result_o.re    = {16'sd0, 16'sd0, a_re.val};
            result_o.im    = {16'sd0, 16'sd0, a_im.val};
            result_o.clip  = a_re.clip | a_im.clip;
        end else begin
            result_o.re    = grad_re_reg;
            result_o.im    = grad_im_reg;
            result_o.clip  = clip_reg;
        end
    end

    assign done_o = done_reg;

endmodule

`default_nettype wire

// File: design/circular_gradient_operator.sv
// Top level: configuration registers, read sequencer and result register.
// Depends on cgo_pkg, cgo_volume_mem and cgo_axis_unit.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  s (in)   | s_valid / s_ready       | s_cmd, s_coord_x/y/z, s_in0..2_re/im
//  m (out)  | m_valid / m_ready       | m_out0..2_re/im, m_saturated
//
// A write beat stores the voxel at the accepting edge.
// A compute beat makes AXES + 1 reads through the single read port of the
// volume memory, then passes a three-stage difference/multiply/round pipe.
// Reset clears control and configuration only; the volume is not cleared.
// The finished result waits in the output register; the next beat is taken
// while it waits, and a second result holds in the pipe until m_ready.
`default_nettype none

module circular_gradient_operator import cgo_pkg::*; #(
    parameter int AXIS_BITS = 5,
    parameter int AXES      = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [AXIS_BITS-1:0]  s_coord_x,
    input  logic [AXIS_BITS-1:0]  s_coord_y,
    input  logic [AXIS_BITS-1:0]  s_coord_z,
    input  sample_t               s_in0_re,
    input  sample_t               s_in0_im,
    input  sample_t               s_in1_re,
    input  sample_t               s_in1_im,
    input  sample_t               s_in2_re,
    input  sample_t               s_in2_im,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sample_t               m_out0_re,
    output sample_t               m_out0_im,
    output sample_t               m_out1_re,
    output sample_t               m_out1_im,
    output sample_t               m_out2_re,
    output sample_t               m_out2_im,
    output logic                  m_saturated
);

    localparam int ADDR_W   = 3 * AXIS_BITS;
    localparam int AXIS_LEN = 1 << AXIS_BITS;
    localparam int SZ_W     = (AXIS_BITS + 1 > SIZE_W) ? AXIS_BITS + 1 : SIZE_W;

    typedef logic [AXIS_BITS-1:0] crd_t;
    typedef logic [AXIS_BITS:0]   esz_t;
    typedef logic [SZ_W-1:0]      szw_t;
    typedef logic [1:0]           cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    cnt_t              cnt_reg;
    crd_t              cx_reg, cy_reg, cz_reg;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic              mode_reg;
    logic [GAIN_W-1:0] gain_reg;
    tag_t              tag_reg;
    logic              m_valid_reg;
    result_t           out_reg;

    esz_t              szx, szy, szz;
    crd_t              nx, ny, nz;
    tag_t              tag_next;
    logic              in_beat, mem_we, mem_re, out_free, load;
    logic [ADDR_W-1:0] waddr, raddr;
    word_t             wdata, rdata;
    logic              done;
    result_t           result;

    function automatic esz_t eff_size(logic [SIZE_W-1:0] s);
        szw_t se;
        esz_t r;
        se = szw_t'(s);
        if (s == '0) begin
            r = esz_t'(1);
        end else if (se > szw_t'(AXIS_LEN)) begin
            r = esz_t'(AXIS_LEN);
        end else begin
            r = esz_t'(se);
        end
        return r;
    endfunction

    // next neighbour in gradient mode, previous in adjoint mode, wrapped
    function automatic crd_t step_coord(crd_t c, esz_t sz, logic adj);
        esz_t n;
        esz_t pm;
        crd_t r;
        n  = esz_t'(c) + esz_t'(1);
        pm = sz - esz_t'(1);
        if (adj) begin
            r = (c == '0) ? crd_t'(pm) : c - crd_t'(1);
        end else begin
            r = (n >= sz) ? '0 : crd_t'(n);
        end
        return r;
    endfunction

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
            mode_reg   <= MODE_GRAD;
            gain_reg   <= GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y: size_y_reg <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z: size_z_reg <= cfg_data[SIZE_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // write path
    assign s_ready = (state_reg == ST_IDLE);
    assign in_beat = s_valid && s_ready;
    assign mem_we  = in_beat && (s_cmd == CMD_WRITE);
    assign waddr   = {s_coord_z, s_coord_y, s_coord_x};
    assign wdata   = {s_in2_im, s_in2_re, s_in1_im, s_in1_re, s_in0_im, s_in0_re};

    // read address sequencing: voxel first, then one neighbour per axis
    always_comb begin
        szx = eff_size(size_x_reg);
        szy = eff_size(size_y_reg);
        szz = eff_size(size_z_reg);
        nx  = cx_reg;
        ny  = cy_reg;
        nz  = cz_reg;
        case (cnt_reg)
            2'd1:    nx = step_coord(cx_reg, szx, mode_reg);
            2'd2:    ny = step_coord(cy_reg, szy, mode_reg);
            2'd3:    nz = step_coord(cz_reg, szz, mode_reg);
            default: ;
        endcase
        raddr         = {nz, ny, nx};
        mem_re        = (state_reg == ST_READ);
        tag_next.vld  = mem_re;
        tag_next.here = (cnt_reg == '0);
        tag_next.last = (cnt_reg == cnt_t'(AXES));
        tag_next.axis = axis_t'(cnt_reg - cnt_t'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_next;
        end
    end

    cgo_volume_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .aclk    (aclk),
        .we_i    (mem_we),
        .waddr_i (waddr),
        .wdata_i (wdata),
        .re_i    (mem_re),
        .raddr_i (raddr),
        .rdata_o (rdata)
    );

    cgo_axis_unit u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tag_i     (tag_reg),
        .rd_data_i (rdata),
        .mode_i    (mode_reg),
        .gain_i    (gain_reg),
        .done_o    (done),
        .result_o  (result)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign load     = ((state_reg == ST_DRAIN && done) || state_reg == ST_HOLD) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat && s_cmd == CMD_COMPUTE) begin
                        cx_reg    <= s_coord_x;
                        cy_reg    <= s_coord_y;
                        cz_reg    <= s_coord_z;
                        cnt_reg   <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (cnt_reg == cnt_t'(AXES)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + cnt_t'(1);
                    end
                end
                ST_DRAIN: begin
                    if (done) begin
                        state_reg <= out_free ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (load) begin
                m_valid_reg <= 1'b1;
                out_reg     <= result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out0_re   = out_reg.re[0];
    assign m_out0_im   = out_reg.im[0];
    assign m_out1_re   = out_reg.re[1];
    assign m_out1_im   = out_reg.im[1];
    assign m_out2_re   = out_reg.re[2];
    assign m_out2_im   = out_reg.im[2];
    assign m_saturated = out_reg.clip;

endmodule

`default_nettype wire

// File: design/cgo_checker.sv
// Port-level checks for circular_gradient_operator, attached by bind.
// Depends only on the top level's port names.
`default_nettype none

module cgo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out0_re,
    input logic [15:0] m_out0_im,
    input logic        m_saturated
);

    // result beat held until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the beat was taken");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out0_re) && $stable(m_out0_im)
                                && $stable(m_saturated))
        else $error("result payload changed while stalled");

    // a compute beat occupies the block
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |=> !s_ready)
        else $error("input taken while a compute beat is in flight");

    // a write beat never produces a result
    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_cmd && !m_valid |=> !m_valid)
        else $error("result appeared after a write beat");

    // the block is free again as soon as a result is posted
    a_rise_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while the block still busy");

endmodule

bind circular_gradient_operator cgo_checker u_cgo_checker (.*);

`default_nettype wire
